>>> sv/sha1bh_pkg.sv
// Shared types, constants and round functions of the SHA-1 block hash engine.
// Depends on nothing; used by sha1bh_ctrl, sha1bh_dp and sha1_block_hash.

package sha1bh_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned WinLen  = 16;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned CvLen   = 5;
  localparam int unsigned PosW    = 4;
  localparam int unsigned RndW    = 7;
  localparam int unsigned IdxW    = 3;

  localparam logic [RndW-1:0] LastRound = 7'd79;
  localparam logic [PosW-1:0] LastSlot  = 4'd15;
  localparam logic [IdxW-1:0] LastIdx   = 3'd4;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t message_word;
    logic  first_of_message;
    logic  last_of_message;
  } in_beat_t;

  typedef struct packed {
    word_t           digest_word;
    logic [IdxW-1:0] digest_index;
    logic            digest_done;
  } out_beat_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic            take_word;   // shift a message word into the window
    logic            load_iv;     // chaining value back to the initial values
    logic            blk_start;   // load a..e from the chaining value
    logic            rnd_en;      // run one round
    logic [RndW-1:0] rnd_t;       // round number
    logic            rnd_last;    // final round: fold a..e into chaining value
    logic            snap_cv;     // digest snapshot from current chaining value
    logic            snap_rnd;    // digest snapshot from final round sums
    logic [IdxW-1:0] out_idx;     // digest word being presented
  } cmd_t;

  localparam word_t Iv0 = 32'h67452301;
  localparam word_t Iv1 = 32'hEFCDAB89;
  localparam word_t Iv2 = 32'h98BADCFE;
  localparam word_t Iv3 = 32'h10325476;
  localparam word_t Iv4 = 32'hC3D2E1F0;

  function automatic word_t iv_word(input logic [IdxW-1:0] i);
    word_t r;
    unique case (i)
      3'd0:    r = Iv0;
      3'd1:    r = Iv1;
      3'd2:    r = Iv2;
      3'd3:    r = Iv3;
      default: r = Iv4;
    endcase
    return r;
  endfunction

  function automatic word_t round_mix(input logic [RndW-1:0] t,
                                      input word_t b, input word_t c,
                                      input word_t d);
    word_t r;
    priority if (t < 7'd20) begin
      r = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      r = b ^ c ^ d;
    end else if (t < 7'd60) begin
      r = (b & c) | (b & d) | (c & d);
    end else begin
      r = b ^ c ^ d;
    end
    return r;
  endfunction

  function automatic word_t round_const(input logic [RndW-1:0] t);
    word_t r;
    priority if (t < 7'd20) begin
      r = 32'h5A827999;
    end else if (t < 7'd40) begin
      r = 32'h6ED9EBA1;
    end else if (t < 7'd60) begin
      r = 32'h8F1BBCDC;
    end else begin
      r = 32'hCA62C1D6;
    end
    return r;
  endfunction

endpackage

>>> sv/sha1bh_ctrl.sv
// Sequencer of the SHA-1 engine: word slot, round counter and digest beats.
// Depends on sha1bh_pkg; drives sha1bh_dp through sha1bh_pkg::cmd_t.

module sha1bh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_first,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output sha1bh_pkg::cmd_t  cmd
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_ROUND
  } state_t;

  state_t                        state_r, state_nxt;
  logic [sha1bh_pkg::PosW-1:0]   pos_r, pos_nxt;
  logic [sha1bh_pkg::RndW-1:0]   rnd_r, rnd_nxt;
  logic                          pend_last_r, pend_last_nxt;
  logic                          emit_r, emit_nxt;
  logic [sha1bh_pkg::IdxW-1:0]   idx_r, idx_nxt;

  logic                          in_acc, out_acc, blk, rnd_end;
  logic [sha1bh_pkg::PosW-1:0]   pos_eff;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign pos_eff = in_first ? '0 : pos_r;
  assign blk     = (pos_eff == sha1bh_pkg::LastSlot);
  assign rnd_end = (state_r == ST_ROUND) && (rnd_r == sha1bh_pkg::LastRound);

  // A last word is held off while the previous digest is still going out.
  assign in_ready  = (state_r == ST_IDLE) && !(emit_r && in_last);
  assign out_valid = emit_r;

  always_comb begin
    cmd.take_word = in_acc;
    cmd.load_iv   = in_acc && in_first;
    cmd.blk_start = in_acc && blk;
    cmd.rnd_en    = (state_r == ST_ROUND);
    cmd.rnd_t     = rnd_r;
    cmd.rnd_last  = rnd_end;
    cmd.snap_cv   = in_acc && in_last && !blk;
    cmd.snap_rnd  = rnd_end && pend_last_r;
    cmd.out_idx   = idx_r;
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    rnd_nxt       = rnd_r;
    pend_last_nxt = pend_last_r;
    emit_nxt      = emit_r;
    idx_nxt       = idx_r;
    if (out_acc) begin
      idx_nxt = idx_r + 3'd1;
      if (idx_r == sha1bh_pkg::LastIdx) begin
        emit_nxt = 1'b0;
        idx_nxt  = '0;
      end
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pos_nxt = in_last ? '0 : pos_eff + 4'd1;
          if (blk) begin
            state_nxt     = ST_ROUND;
            rnd_nxt       = '0;
            pend_last_nxt = in_last;
          end else if (in_last) begin
            emit_nxt = 1'b1;
            idx_nxt  = '0;
          end
        end
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_end) begin
          state_nxt     = ST_IDLE;
          rnd_nxt       = '0;
          pend_last_nxt = 1'b0;
          if (pend_last_r) begin
            emit_nxt = 1'b1;
            idx_nxt  = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      rnd_r       <= '0;
      pend_last_r <= 1'b0;
      emit_r      <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      rnd_r       <= rnd_nxt;
      pend_last_r <= pend_last_nxt;
      emit_r      <= emit_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // A new snapshot must never overwrite a digest still being sent.
  a_snap_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.snap_cv || cmd.snap_rnd) |-> !emit_r)
    else $error("digest snapshot while emitting");

  // Round counter sits at zero between blocks.
  a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (rnd_r == '0))
    else $error("round counter not cleared");

  // Digest index stays within the five words.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= sha1bh_pkg::LastIdx)
    else $error("digest index out of range");

  // Starting a block always leads into the first round.
  a_blk_round: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.blk_start |=> (state_r == ST_ROUND) && (rnd_r == '0))
    else $error("block start without rounds");

endmodule

>>> sv/sha1bh_dp.sv
// Datapath of the SHA-1 engine: schedule shift line, a..e, chaining value, digest.
// Depends on sha1bh_pkg; commanded by sha1bh_ctrl.

module sha1bh_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha1bh_pkg::cmd_t       cmd,
  input  sha1bh_pkg::word_t      word_in,
  output sha1bh_pkg::word_t      digest_word
);

  localparam int unsigned Win = sha1bh_pkg::WinLen;
  localparam int unsigned Cv  = sha1bh_pkg::CvLen;

  // Tap 0 is the oldest word; every round shifts the line by one and appends the round's schedule word.
  sha1bh_pkg::word_t sch_r [Win];
  sha1bh_pkg::word_t cv_r  [Cv];
  sha1bh_pkg::word_t dig_r [Cv];
  sha1bh_pkg::word_t a_r, b_r, c_r, d_r, e_r;

  sha1bh_pkg::word_t cv_src [Cv];
  sha1bh_pkg::word_t w_exp, w_cur, tmp, sum_a, sum_b, sum_c, sum_d, sum_e;

  always_comb begin
    for (int i = 0; i < Cv; i++) begin
      cv_src[i] = cmd.load_iv ? sha1bh_pkg::iv_word(sha1bh_pkg::IdxW'(i)) : cv_r[i];
    end
  end

  always_comb begin
    w_exp = sch_r[13] ^ sch_r[8] ^ sch_r[2] ^ sch_r[0];
    w_exp = {w_exp[30:0], w_exp[31]};
    w_cur = (cmd.rnd_t < 7'(Win)) ? sch_r[0] : w_exp;
    tmp   = {a_r[26:0], a_r[31:27]} + sha1bh_pkg::round_mix(cmd.rnd_t, b_r, c_r, d_r)
          + e_r + sha1bh_pkg::round_const(cmd.rnd_t) + w_cur;
    sum_a = cv_r[0] + tmp;
    sum_b = cv_r[1] + a_r;
    sum_c = cv_r[2] + {b_r[1:0], b_r[31:2]};
    sum_d = cv_r[3] + c_r;
    sum_e = cv_r[4] + d_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.take_word) begin
      for (int i = 0; i < Win - 1; i++) sch_r[i] <= sch_r[i+1];
      sch_r[Win-1] <= word_in;
    end else if (cmd.rnd_en) begin
      for (int i = 0; i < Win - 1; i++) sch_r[i] <= sch_r[i+1];
      sch_r[Win-1] <= w_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Cv; i++) cv_r[i] <= sha1bh_pkg::iv_word(sha1bh_pkg::IdxW'(i));
      a_r <= '0;
      b_r <= '0;
      c_r <= '0;
      d_r <= '0;
      e_r <= '0;
    end else begin
      if (cmd.load_iv) begin
        for (int i = 0; i < Cv; i++) cv_r[i] <= cv_src[i];
      end
      if (cmd.blk_start) begin
        a_r <= cv_src[0];
        b_r <= cv_src[1];
        c_r <= cv_src[2];
        d_r <= cv_src[3];
        e_r <= cv_src[4];
      end else if (cmd.rnd_en) begin
        a_r <= tmp;
        b_r <= a_r;
        c_r <= {b_r[1:0], b_r[31:2]};
        d_r <= c_r;
        e_r <= d_r;
        if (cmd.rnd_last) begin
          cv_r[0] <= sum_a;
          cv_r[1] <= sum_b;
          cv_r[2] <= sum_c;
          cv_r[3] <= sum_d;
          cv_r[4] <= sum_e;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap_cv) begin
      for (int i = 0; i < Cv; i++) dig_r[i] <= cv_src[i];
    end else if (cmd.snap_rnd) begin
      dig_r[0] <= sum_a;
      dig_r[1] <= sum_b;
      dig_r[2] <= sum_c;
      dig_r[3] <= sum_d;
      dig_r[4] <= sum_e;
    end
  end

  assign digest_word = dig_r[cmd.out_idx];

endmodule

>>> sv/sha1_block_hash.sv
// Top level of the SHA-1 block hash engine.
// Depends on sha1bh_pkg, sha1bh_ctrl and sha1bh_dp.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one padded 32-bit message
//    word per beat, big-endian, with first_of_message and last_of_message.
//    A first mark reloads the initial hash values and restarts the block.
//  - Output channel (out_valid/out_ready/out_data): after a last word, five
//    beats carry the digest, index 0 (most significant) to 4; the fifth beat
//    has digest_done set.
//  - Throughput: a word that does not complete a block is only shifted in.
//    The sixteenth word of a block starts the 80 rounds, one per cycle in
//    the single round adder; in_ready stays low while the rounds run.
//  - Output timing: the first digest beat shows in the cycle after a last
//    word that does not complete a block (partial block is dropped), or in
//    the cycle after the final round when it does.
//  - The digest sits in its own snapshot register, so words of the next
//    message are taken while the receiver stalls; only a further last word
//    is held off until all five beats have gone out.
//  - Reset (rst_n low, synchronous): chaining value to the initial values,
//    no digest pending, word slot and round counter at zero.

module sha1_block_hash (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha1bh_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha1bh_pkg::out_beat_t out_data
);

  sha1bh_pkg::cmd_t  cmd;
  sha1bh_pkg::word_t digest_word;

  sha1bh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_first  (in_data.first_of_message),
    .in_last   (in_data.last_of_message),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sha1bh_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .word_in     (in_data.message_word),
    .digest_word (digest_word)
  );

  // Index and done flag come straight from the beat counter.
  always_comb begin
    out_data.digest_word  = digest_word;
    out_data.digest_index = cmd.out_idx;
    out_data.digest_done  = (cmd.out_idx == sha1bh_pkg::LastIdx);
  end

endmodule
